@@ design/srtd_pkg.sv @@
// shared types, constants and codes for the step rate timer divider
package srtd_pkg;

  localparam int unsigned CLK_W   = 28;
  localparam int unsigned MSTEP_W = 9;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CFG_W   = 28;
  localparam int unsigned NUM_W   = 39;  // clock_hz * 1600 < 2^39
  localparam int unsigned DEN_W   = 25;  // speed * microsteps < 2^25
  localparam int unsigned LIM_W   = 41;  // period_limit * den < 2^41
  localparam int unsigned DIV_W   = 17;  // divisor up to 65536
  localparam int unsigned SHF_W   = LIM_W + DIV_W;
  localparam int unsigned MUL_A_W = 28;
  localparam int unsigned MUL_B_W = 25;

  localparam logic [MUL_B_W-1:0] K_SCALE0    = MUL_B_W'(1600);
  localparam logic [MUL_B_W-1:0] K_SCALE1    = MUL_B_W'(10);
  localparam logic [DIV_W:0]     MAX_DIVISOR = (DIV_W+1)'(65536);
  localparam logic [15:0]        PERIOD_SAT  = 16'hffff;

  localparam logic [CLK_W-1:0]   CLOCK_HZ_RST = CLK_W'(72000000);
  localparam logic [MSTEP_W-1:0] MSTEP_RST    = MSTEP_W'(16);
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = LIMIT_W'(60000);

  typedef enum logic [1:0] {
    REG_CLOCK_HZ = 2'd0,
    REG_MSTEP    = 2'd1,
    REG_LIMIT    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_RATE = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_NUM,
    S_MUL_DEN,
    S_MUL_LIM,
    S_DIV1_START,
    S_DIV1_WAIT,
    S_MUL_DD,
    S_DIV2_START,
    S_DIV2_WAIT,
    S_DONE
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic over;
    logic rem_nz;
  } div_stat_t;

endpackage

@@ design/srtd_if.sv @@
// handshake channels for commands, results and register writes
interface srtd_cmd_if import srtd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;
  logic               scale_select;
  logic               clockwise;

  modport source (output valid, output speed, output scale_select, output clockwise,
                  input ready);
  modport sink (input valid, input speed, input scale_select, input clockwise,
                output ready);
endinterface

interface srtd_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] prescaler;
  logic [15:0] period;
  logic        direction_level;
  logic [1:0]  status;

  modport source (output valid, output prescaler, output period, output direction_level,
                  output status, input ready);
  modport sink (input valid, input prescaler, input period, input direction_level,
                input status, output ready);
endinterface

interface srtd_cfg_if import srtd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/srtd_div.sv @@
// restoring divider, one quotient bit per cycle, with quotient overflow check
module srtd_div import srtd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             long_quot,
  input  logic [NUM_W-1:0] dividend,
  input  logic [LIM_W-1:0] divisor,
  output logic [DIV_W-1:0] quot,
  output div_stat_t        stat
);

  logic             busy;
  logic             done;
  logic [4:0]       cnt;
  logic             over;
  logic [NUM_W-1:0] rem;
  logic [DIV_W-1:0] q;
  logic [SHF_W-1:0] dsh;

  logic [SHF_W-1:0] shifted_c;
  logic             over_c;
  logic             take_c;

  // divisor aligned to the top quotient bit plus one
  assign shifted_c = long_quot ? {divisor, {DIV_W{1'b0}}}
                               : {1'b0, divisor, {(DIV_W-1){1'b0}}};
  assign over_c = {{(SHF_W-NUM_W){1'b0}}, dividend} >= shifted_c;
  assign take_c = {{(SHF_W-NUM_W){1'b0}}, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= !over_c;
        done <= over_c;
        cnt  <= long_quot ? 5'(DIV_W) : 5'(DIV_W - 1);
      end else if (busy) begin
        cnt  <= cnt - 5'd1;
        busy <= (cnt != 5'd1);
        done <= (cnt == 5'd1);
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      over <= over_c;
      rem  <= dividend;
      q    <= '0;
      dsh  <= shifted_c >> 1;
    end else if (busy) begin
      if (take_c) begin
        rem <= rem - dsh[NUM_W-1:0];
      end
      q   <= {q[DIV_W-2:0], take_c};
      dsh <= dsh >> 1;
    end
  end

  assign quot        = q;
  assign stat.done   = done;
  assign stat.over   = over;
  assign stat.rem_nz = (rem != '0);

endmodule

@@ design/step_rate_timer_divider.sv @@
// step rate timer divider: one start command in, one timer setting beat out
// sequence: from command accept to result valid, 3 multiplies, the divider steps
//   for the divisor search, 1 multiply and the divider steps for the period (a zero
//   rate ends after the multiplies); the shared multiplier and the divider set its length
// commands: taken one at a time, only in the idle state; a new command is taken while the
//   previous result still waits in the output register
// reset: synchronous, restores clock_hz 72000000, microsteps 16, limit 60000
module step_rate_timer_divider import srtd_pkg::*; (
  input  logic clk,
  input  logic rst,
  srtd_cmd_if.sink   cmd,
  srtd_res_if.source res,
  srtd_cfg_if.sink   cfg
);

  state_t state;
  state_t state_next;

  logic [CLK_W-1:0]   clock_hz;
  logic [MSTEP_W-1:0] microstep_count;
  logic [LIMIT_W-1:0] period_limit;

  logic [SPEED_W-1:0] speed_r;
  logic               scale_r;
  logic               dir_r;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [LIM_W-1:0]   lim;
  logic [DIV_W-1:0]   div;
  logic               over_r;
  logic [15:0]        presc_r;
  logic [15:0]        per_r;
  status_t            status_r;

  logic        res_valid;
  logic [15:0] res_prescaler;
  logic [15:0] res_period;
  logic        res_dir;
  logic [1:0]  res_status;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [LIM_W-1:0]   prod;
  logic [LIM_W-1:0]   prod_dd;

  logic               div_start;
  logic               div_long;
  logic [LIM_W-1:0]   div_divisor;
  logic [DIV_W-1:0]   div_quot;
  div_stat_t          div_stat;
  logic [DIV_W:0]     div_ceil;
  logic               out_free;
  logic               cmd_ready;

  assign out_free = !res_valid || res.ready;
  assign prod     = LIM_W'(mul_a * mul_b);
  assign div_ceil = {1'b0, div_quot} + {{DIV_W{1'b0}}, div_stat.rem_nz};

  srtd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .long_quot (div_long),
    .dividend  (num),
    .divisor   (div_divisor),
    .quot      (div_quot),
    .stat      (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (cmd.valid) state_next = S_MUL_NUM;
      S_MUL_NUM:    state_next = S_MUL_DEN;
      S_MUL_DEN:    state_next = S_MUL_LIM;
      S_MUL_LIM:    state_next = (den == '0) ? S_DONE : S_DIV1_START;
      S_DIV1_START: state_next = (num == '0) ? S_MUL_DD : S_DIV1_WAIT;
      S_DIV1_WAIT:  if (div_stat.done) state_next = S_MUL_DD;
      S_MUL_DD:     state_next = S_DIV2_START;
      S_DIV2_START: state_next = S_DIV2_WAIT;
      S_DIV2_WAIT:  if (div_stat.done) state_next = S_DONE;
      S_DONE:       if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // control outputs and shared multiplier operands
  always_comb begin
    cmd_ready   = 1'b0;
    div_start   = 1'b0;
    div_long    = 1'b0;
    div_divisor = lim;
    mul_a       = '0;
    mul_b       = '0;
    case (state)
      S_IDLE: cmd_ready = 1'b1;
      S_MUL_NUM: begin
        mul_a = clock_hz;
        mul_b = scale_r ? K_SCALE1 : K_SCALE0;
      end
      S_MUL_DEN: begin
        mul_a = MUL_A_W'(speed_r);
        mul_b = MUL_B_W'(microstep_count);
      end
      S_MUL_LIM: begin
        mul_a = MUL_A_W'(period_limit);
        mul_b = den;
      end
      S_DIV1_START: begin
        div_start = (num != '0);
        div_long  = 1'b1;
      end
      S_MUL_DD: begin
        mul_a = MUL_A_W'(den);
        mul_b = MUL_B_W'(div);
      end
      S_DIV2_START: begin
        div_start   = 1'b1;
        div_divisor = prod_dd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      clock_hz        <= CLOCK_HZ_RST;
      microstep_count <= MSTEP_RST;
      period_limit    <= LIMIT_RST;
      res_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          REG_CLOCK_HZ: clock_hz        <= cfg.data[CLK_W-1:0];
          REG_MSTEP:    microstep_count <= cfg.data[MSTEP_W-1:0];
          REG_LIMIT:    period_limit    <= cfg.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          speed_r <= cmd.speed;
          scale_r <= cmd.scale_select;
          dir_r   <= cmd.clockwise;
        end
      end
      S_MUL_NUM: num <= prod[NUM_W-1:0];
      S_MUL_DEN: den <= prod[DEN_W-1:0];
      S_MUL_LIM: begin
        lim      <= prod;
        presc_r  <= '0;
        per_r    <= '0;
        status_r <= STATUS_ZERO_RATE;
      end
      S_DIV1_START: begin
        if (num == '0) begin
          div    <= DIV_W'(1);
          over_r <= 1'b0;
        end
      end
      S_DIV1_WAIT: begin
        if (div_stat.done) begin
          if (div_stat.over || div_ceil > MAX_DIVISOR) begin
            div    <= MAX_DIVISOR[DIV_W-1:0];
            over_r <= 1'b1;
          end else if (div_ceil == '0) begin
            div    <= DIV_W'(1);
            over_r <= 1'b0;
          end else begin
            div    <= div_ceil[DIV_W-1:0];
            over_r <= 1'b0;
          end
        end
      end
      S_MUL_DD: prod_dd <= prod;
      S_DIV2_WAIT: begin
        if (div_stat.done) begin
          presc_r  <= 16'(div - DIV_W'(1));
          per_r    <= div_stat.over ? PERIOD_SAT : div_quot[15:0];
          status_r <= over_r ? STATUS_OVERFLOW : STATUS_OK;
        end
      end
      default: ;
    endcase
    if (state == S_DONE && out_free) begin
      res_prescaler <= presc_r;
      res_period    <= per_r;
      res_dir       <= dir_r;
      res_status    <= status_r;
    end
  end

  assign cmd.ready           = cmd_ready;
  assign cfg.ready           = 1'b1;
  assign res.valid           = res_valid;
  assign res.prescaler       = res_prescaler;
  assign res.period          = res_period;
  assign res.direction_level = res_dir;
  assign res.status          = res_status;

endmodule

@@ design/srtd_check.sv @@
// port level checks for the step rate timer divider, bound to the top level
module srtd_check import srtd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_prescaler,
  input logic [15:0] res_period,
  input logic [1:0]  res_status
);

  // a command beat starts a long sequence, so no second beat right behind it
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken on the cycle after a command beat");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_prescaler) && $stable(res_period)
      && $stable(res_status))
    else $error("stalled result changed");

  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == STATUS_ZERO_RATE |-> res_prescaler == '0 && res_period == '0)
    else $error("zero rate result with non-zero timer settings");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == STATUS_OVERFLOW |-> res_prescaler == 16'hffff)
    else $error("divisor overflow without saturated prescaler");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status != 2'd3)
    else $error("undefined status code");

endmodule

bind step_rate_timer_divider srtd_check u_srtd_check (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_prescaler (res.prescaler),
  .res_period    (res.period),
  .res_status    (res.status)
);

@@ sim/step_rate_timer_divider_tb.sv @@
// testbench for the step rate timer divider: directed and random start commands, checked beat by beat
`timescale 1ns / 100ps

module step_rate_timer_divider_tb import srtd_pkg::*; ();

  localparam int unsigned DRAIN_CYCLES = 60;     // a little over the command latency
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned CHUNKS = 5;
  localparam int unsigned CHUNK_ITEMS = 60;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0] CLOCK_MAX = {CFG_W{1'b1}};

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               scale_select;
    logic               clockwise;
  } start_cmd_t;

  typedef struct {
    logic [15:0] prescaler;
    logic [15:0] period;
    logic        direction_level;
    status_t     status;
  } timer_setting_t;

  logic clk;
  logic rst;

  srtd_cmd_if cmd_bus ();
  srtd_res_if res_bus ();
  srtd_cfg_if cfg_bus ();

  step_rate_timer_divider dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  // shadow copy of the registers
  logic [CLK_W-1:0]   clock_hz_cfg = CLOCK_HZ_RST;
  logic [MSTEP_W-1:0] mstep_cfg    = MSTEP_RST;
  logic [LIMIT_W-1:0] limit_cfg    = LIMIT_RST;

  timer_setting_t pending_settings[$];
  int unsigned    mismatch_count = 0;
  int unsigned    source_gap_pct = 0;
  int unsigned    sink_stall_pct = 0;
  int unsigned    hold_left = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic timer_setting_t predict_setting(input start_cmd_t c);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] lim;
    logic [63:0] divisor;
    logic [63:0] per;
    logic        over;
    timer_setting_t s;
    num = 64'(clock_hz_cfg) * (c.scale_select ? 64'(K_SCALE1) : 64'(K_SCALE0));
    den = 64'(c.speed) * 64'(mstep_cfg);
    s.direction_level = c.clockwise;
    s.prescaler = '0;
    s.period = '0;
    s.status = STATUS_OK;
    if (den == 0) begin
      s.status = STATUS_ZERO_RATE;
    end else begin
      lim = 64'(limit_cfg) * den;
      if (num == 0) begin
        divisor = 1;
        over = 1'b0;
      end else if (lim == 0) begin
        // no divisor can meet a zero limit
        divisor = 64'(MAX_DIVISOR);
        over = 1'b1;
      end else begin
        divisor = (num + lim - 1) / lim;
        over = divisor > 64'(MAX_DIVISOR);
        if (over) divisor = 64'(MAX_DIVISOR);
      end
      per = num / (den * divisor);
      if (per > 64'(PERIOD_SAT)) per = 64'(PERIOD_SAT);
      s.prescaler = 16'(divisor - 1);
      s.period = per[15:0];
      s.status = over ? STATUS_OVERFLOW : STATUS_OK;
    end
    return s;
  endfunction

  task automatic send_command(input start_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < source_gap_pct) begin
      cmd_bus.valid = 1'b0;
      cmd_bus.speed = SPEED_W'($urandom);
      cmd_bus.scale_select = 1'($urandom);
      cmd_bus.clockwise = 1'($urandom);
      @(negedge clk);
    end
    cmd_bus.valid = 1'b1;
    cmd_bus.speed = c.speed;
    cmd_bus.scale_select = c.scale_select;
    cmd_bus.clockwise = c.clockwise;
    do @(posedge clk); while (!cmd_bus.ready);
    pending_settings.push_back(predict_setting(c));
  endtask

  task automatic send(input int unsigned speed, input bit scale, input bit cw);
    start_cmd_t c;
    c.speed = SPEED_W'(speed);
    c.scale_select = scale;
    c.clockwise = cw;
    send_command(c);
  endtask

  // lower valid right after the last beat, then let the block go quiet
  task automatic drain_results();
    @(negedge clk);
    cmd_bus.valid = 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_CLOCK_HZ: clock_hz_cfg = data[CLK_W-1:0];
      REG_MSTEP:    mstep_cfg = data[MSTEP_W-1:0];
      REG_LIMIT:    limit_cfg = data[LIMIT_W-1:0];
      default:      ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] clock_hz, input logic [CFG_W-1:0] mstep,
                              input logic [CFG_W-1:0] limit);
    write_register(REG_CLOCK_HZ, clock_hz);
    write_register(REG_MSTEP, mstep);
    write_register(REG_LIMIT, limit);
  endtask

  task automatic random_config();
    logic [CFG_W-1:0] clock_hz;
    logic [CFG_W-1:0] mstep;
    logic [CFG_W-1:0] limit;
    int unsigned r;
    r = $urandom_range(9);
    clock_hz = (r == 0) ? CLOCK_MAX : (r == 1) ? CFG_W'(1) : (r == 2) ? CFG_W'(CLOCK_HZ_RST) :
               CFG_W'($urandom_range(200000000, 1));
    r = $urandom_range(9);
    mstep = (r == 0) ? CFG_W'(1) : (r == 1) ? CFG_W'(256) : (r == 2) ? CFG_W'(MSTEP_RST) :
            CFG_W'($urandom_range(256, 1));
    // junk above the register width must be dropped
    mstep[CFG_W-1:MSTEP_W] = (CFG_W-MSTEP_W)'($urandom);
    r = $urandom_range(9);
    limit = (r == 0) ? CFG_W'(1) : (r == 1) ? CFG_W'(65535) : CFG_W'($urandom_range(65535, 1));
    limit[CFG_W-1:LIMIT_W] = (CFG_W-LIMIT_W)'($urandom);
    apply_config(clock_hz, mstep, limit);
  endtask

  function automatic start_cmd_t random_command();
    start_cmd_t c;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) c.speed = '0;
    else if (r < 30) c.speed = SPEED_W'($urandom_range(15, 1));
    else if (r < 60) c.speed = SPEED_W'($urandom_range(2000, 16));
    else c.speed = SPEED_W'($urandom);
    c.scale_select = 1'($urandom);
    c.clockwise = 1'($urandom);
    return c;
  endfunction

  task automatic run_random_chunks();
    for (int unsigned k = 0; k < CHUNKS; k++) begin
      random_config();
      for (int unsigned n = 0; n < CHUNK_ITEMS; n++) send_command(random_command());
      drain_results();
    end
  endtask

  task automatic test_directed();
    source_gap_pct = 20;
    sink_stall_pct = 20;
    // reset settings: zero speed, overflow at the slowest speeds, field extremes
    send(0, 0, 1);
    send(1, 0, 0);
    send(1, 1, 1);
    send(2, 0, 1);
    send(100, 0, 0);
    send(65535, 0, 1);
    send(65535, 1, 0);
    send(16'h5555, 1, 1);
    send(16'haaaa, 0, 0);
    drain_results();
    // zero clock gives divisor one and period zero
    write_register(REG_CLOCK_HZ, '0);
    send(500, 0, 1);
    send(1, 1, 0);
    drain_results();
    // zero limit counts as overflow, zero speed still wins
    apply_config(CFG_W'(CLOCK_HZ_RST), CFG_W'(MSTEP_RST), '0);
    send(1000, 0, 1);
    send(0, 1, 0);
    drain_results();
    // zero microsteps means zero rate
    apply_config(CFG_W'(CLOCK_HZ_RST), '0, CFG_W'(LIMIT_RST));
    send(1000, 1, 1);
    drain_results();
    // largest clock and factor
    apply_config(CLOCK_MAX, CFG_W'(511), CFG_W'(65535));
    send(65535, 0, 1);
    send(1, 0, 0);
    drain_results();
    // saturated period on overflow
    apply_config(CLOCK_MAX, CFG_W'(1), CFG_W'(1));
    send(1, 0, 1);
    send(65535, 1, 0);
    drain_results();
    apply_config(CFG_W'(1), CFG_W'(1), CFG_W'(1));
    send(65535, 1, 1);
    send(1, 1, 0);
    drain_results();
    // unused index leaves every register alone
    write_register(REG_UNUSED, CLOCK_MAX);
    send(3, 0, 1);
    drain_results();
  endtask

  task automatic test_slow_sink();
    source_gap_pct = 36;
    sink_stall_pct = 75;
    run_random_chunks();
  endtask

  task automatic test_slow_source();
    source_gap_pct = 75;
    sink_stall_pct = 36;
    run_random_chunks();
  endtask

  task automatic test_full_rate();
    source_gap_pct = 0;
    sink_stall_pct = 0;
    run_random_chunks();
  endtask

  // sink holds off for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    source_gap_pct = 0;
    sink_stall_pct = 0;
    random_config();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (int unsigned n = 0; n < 24; n++) send_command(random_command());
    drain_results();
  endtask

  // result sink
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_bus.ready = 1'b0;
        hold_left--;
      end else begin
        res_bus.ready = ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    timer_setting_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_settings.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_settings.pop_front();
        if (res_bus.prescaler !== want.prescaler)
          report_mismatch($sformatf("prescaler %0d, expected %0d", res_bus.prescaler,
                                    want.prescaler));
        if (res_bus.period !== want.period)
          report_mismatch($sformatf("period %0d, expected %0d", res_bus.period, want.period));
        if (res_bus.direction_level !== want.direction_level)
          report_mismatch($sformatf("direction %b, expected %b", res_bus.direction_level,
                                    want.direction_level));
        if (res_bus.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", res_bus.status, want.status));
      end
    end
  end

  // watchdog: ends the run when no beat moves for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.speed = '0;
    cmd_bus.scale_select = 1'b0;
    cmd_bus.clockwise = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_slow_sink();
    test_slow_source();
    test_full_rate();
    test_output_backpressure();

    if (pending_settings.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_settings.size()));
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
design/srtd_pkg.sv
design/srtd_if.sv
design/srtd_div.sv
design/step_rate_timer_divider.sv
design/srtd_check.sv
sim/step_rate_timer_divider_tb.sv
